// ===== hdl/hc2924_pkg.sv =====
package hc2924_pkg;

  localparam int CodeBits = 30;
  localparam int EncBits  = 29;
  localparam int DataBits = 24;
  localparam int ParBits  = 5;

  // operation codes
  localparam logic FuncEncode = 1'b0;
  localparam logic FuncDecode = 1'b1;

  typedef logic [CodeBits-1:0] code_word_t;
  typedef logic [DataBits-1:0] data_word_t;
  typedef logic [ParBits-1:0]  syn_t;

  // code position of each data bit, most significant data bit first
  localparam logic [ParBits-1:0] DATA_POS [DataBits] = '{
    5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10, 5'd11, 5'd12,
    5'd13, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
    5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29
  };

  // spread data bits over their code positions, parity positions left zero
  function automatic code_word_t place_data(input data_word_t d);
    code_word_t w;
    w = '0;
    for (int i = 0; i < DataBits; i++) begin
      w[DATA_POS[i] - 5'd1] = d[DataBits-1-i];
    end
    return w;
  endfunction

  // xor of the positions of all set bits
  function automatic syn_t word_syndrome(input code_word_t w);
    syn_t s;
    s = '0;
    for (int j = 0; j < CodeBits; j++) begin
      if (w[j]) begin
        s = s ^ ParBits'(j + 1);
      end
    end
    return s;
  endfunction

  // gather data bits back from their code positions
  function automatic data_word_t extract_data(input code_word_t w);
    data_word_t d;
    d = '0;
    for (int i = 0; i < DataBits; i++) begin
      d[DataBits-1-i] = w[DATA_POS[i] - 5'd1];
    end
    return d;
  endfunction

endpackage

// ===== hdl/hamming_29_24_codec_top.sv =====
// Hamming single-error-correcting codec for 24-bit groups.
// Input channel: in_valid / in_stall with in_func, in_data_in, in_code_in.
//   in_func selects encode (data_in -> 29-bit code word) or decode
//   (30-bit received word -> corrected data and syndrome).
// Result channel: out_valid / out_stall with out_code_out, out_data_out,
//   out_syndrome; fields that do not belong to the operation read zero.
// A request is taken at a clock edge with valid high and stall low.
// Pipeline: three register stages: placement, syndrome tree, correction and
//   output register.
// Throughput: one request per cycle while out_stall is low.
// Stall: while the output holds a result and out_stall is high the whole
//   pipeline freezes and in_stall goes high; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits; no result is
//   pending afterwards.
module hamming_29_24_codec_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [23:0] in_data_in,
  input  logic [29:0] in_code_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [28:0] out_code_out,
  output logic [23:0] out_data_out,
  output logic [4:0]  out_syndrome
);

  logic                   adv;
  logic                   v1_r, v2_r, v3_r;
  logic                   func1_r, func2_r;
  hc2924_pkg::code_word_t word1_r, word2_r;
  hc2924_pkg::syn_t       syn2_r;

  hc2924_pkg::code_word_t word1_nxt;
  hc2924_pkg::syn_t       syn2_nxt;
  hc2924_pkg::code_word_t flip;
  hc2924_pkg::code_word_t corrected;
  hc2924_pkg::code_word_t par_word;
  logic [hc2924_pkg::EncBits-1:0]  code_nxt;
  hc2924_pkg::data_word_t          data_nxt;
  hc2924_pkg::syn_t                syn3_nxt;
  logic [hc2924_pkg::EncBits-1:0]  code_r;
  hc2924_pkg::data_word_t          data_r;
  hc2924_pkg::syn_t                syn3_r;

  // pipeline moves unless a finished result is held back
  assign adv      = !(v3_r && out_stall);
  assign in_stall = !adv;

  // stage 1: encode places data bits, decode takes the word as received
  always_comb begin
    if (in_func == hc2924_pkg::FuncDecode) begin
      word1_nxt = in_code_in;
    end else begin
      word1_nxt = hc2924_pkg::place_data(in_data_in);
    end
  end

  // stage 2: syndrome tree
  assign syn2_nxt = hc2924_pkg::word_syndrome(word1_r);

  // stage 3: flip the named bit, or fill the parity positions
  always_comb begin
    flip     = '0;
    par_word = word2_r;
    for (int j = 0; j < hc2924_pkg::CodeBits; j++) begin
      flip[j] = (syn2_r == hc2924_pkg::ParBits'(j + 1));
    end
    for (int k = 0; k < hc2924_pkg::ParBits; k++) begin
      par_word[(1 << k) - 1] = syn2_r[k];
    end
    corrected = word2_r ^ flip;
    if (func2_r == hc2924_pkg::FuncDecode) begin
      code_nxt = '0;
      data_nxt = hc2924_pkg::extract_data(corrected);
      syn3_nxt = syn2_r;
    end else begin
      code_nxt = par_word[hc2924_pkg::EncBits-1:0];
      data_nxt = '0;
      syn3_nxt = '0;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= in_func;
      word1_r <= word1_nxt;
      func2_r <= func1_r;
      word2_r <= word1_r;
      syn2_r  <= syn2_nxt;
      code_r  <= code_nxt;
      data_r  <= data_nxt;
      syn3_r  <= syn3_nxt;
    end
  end

  assign out_valid    = v3_r;
  assign out_code_out = code_r;
  assign out_data_out = data_r;
  assign out_syndrome = syn3_r;

endmodule

// ===== hdl/hc2924_checker.sv =====
module hc2924_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [28:0] out_code_out,
  input logic [23:0] out_data_out,
  input logic [4:0]  out_syndrome
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_out)
      && $stable(out_data_out) && $stable(out_syndrome))
    else $error("result changed while stalled");

  // every code word sent out has a zero syndrome
  a_enc_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hc2924_pkg::word_syndrome({1'b0, out_code_out}) == '0)
    else $error("encoded word has nonzero syndrome");

  // encode and decode fields never mix
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_out != '0 |-> out_data_out == '0 && out_syndrome == '0)
    else $error("encode result carries decode fields");

  // an empty output never holds back the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind hamming_29_24_codec_top hc2924_checker u_hc2924_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_code_out (out_code_out),
  .out_data_out (out_data_out),
  .out_syndrome (out_syndrome)
);

// ===== sim/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // one result as the block should deliver it
  typedef struct packed {
    logic [28:0] code;
    logic [23:0] data;
    logic [4:0]  syn;
  } codec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = hc2924_pkg::FuncEncode;
  logic [23:0] in_data_in = '0;
  logic [29:0] in_code_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [28:0] out_code_out;
  logic [23:0] out_data_out;
  logic [4:0]  out_syndrome;

  codec_result_t pending_results[$];
  int            outstanding = 0;
  int            error_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  hamming_29_24_codec_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_in   (in_data_in),
    .in_code_in   (in_code_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_code_out (out_code_out),
    .out_data_out (out_data_out),
    .out_syndrome (out_syndrome)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL hamming_29_24_codec_top");
    $finish;
  end

  // true for positions 1, 2, 4, 8, 16
  function automatic bit is_parity_pos(input int p);
    return (p & (p - 1)) == 0;
  endfunction

  // build the 29-bit code word: data msb first over non-parity positions
  function automatic logic [28:0] hamming_encode(input hc2924_pkg::data_word_t d);
    logic [29:0] w;
    logic [4:0]  chk;
    int          idx;
    w   = '0;
    chk = '0;
    idx = 23;
    for (int p = 1; p <= 29; p++) begin
      if (!is_parity_pos(p)) begin
        if (d[idx]) begin
          w[p-1] = 1'b1;
          chk    = chk ^ 5'(p);
        end
        idx--;
      end
    end
    for (int k = 0; k < 5; k++) begin
      w[(1 << k) - 1] = chk[k];
    end
    return w[28:0];
  endfunction

  // syndrome over positions 1..30, flip the named bit, pull the data back out
  function automatic codec_result_t hamming_decode(input hc2924_pkg::code_word_t w);
    codec_result_t r;
    logic [4:0]    s;
    logic [29:0]   fixed;
    int            idx;
    s = '0;
    for (int p = 1; p <= 30; p++) begin
      if (w[p-1]) s = s ^ 5'(p);
    end
    fixed = w;
    // syndrome 31 points outside the word, nothing to flip
    if (s != 5'd0 && s <= 5'd30) fixed[s-1] = ~fixed[s-1];
    r      = '0;
    r.syn  = s;
    idx    = 23;
    for (int p = 1; p <= 29; p++) begin
      if (!is_parity_pos(p)) begin
        r.data[idx] = fixed[p-1];
        idx--;
      end
    end
    return r;
  endfunction

  function automatic codec_result_t predict_result(input logic f,
                                                   input hc2924_pkg::data_word_t d,
                                                   input hc2924_pkg::code_word_t c);
    codec_result_t r;
    if (f == hc2924_pkg::FuncEncode) begin
      r      = '0;
      r.code = hamming_encode(d);
    end else begin
      r = hamming_decode(c);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // drive one request and hold it until the block takes it
  task automatic send_request(input logic f, input hc2924_pkg::data_word_t d,
                              input hc2924_pkg::code_word_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_data_in <= d;
    in_code_in <= c;
    do @(posedge clk); while (in_stall);
    pending_results = {pending_results, predict_result(f, d, c)};
    outstanding++;
  endtask

  // hold the input quiet until every pending result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // result checking and receiver stall
  always @(posedge clk) begin
    codec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        outstanding--;
        if (out_code_out !== want.code) begin
          report_mismatch($sformatf("code_out got 0x%0h expected 0x%0h",
                                    out_code_out, want.code));
        end
        if (out_data_out !== want.data) begin
          report_mismatch($sformatf("data_out got 0x%0h expected 0x%0h",
                                    out_data_out, want.data));
        end
        if (out_syndrome !== want.syn) begin
          report_mismatch($sformatf("syndrome got 0x%0h expected 0x%0h",
                                    out_syndrome, want.syn));
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // encode at the data extremes, code_in garbage must be ignored
  task automatic test_encode_extremes();
    send_request(hc2924_pkg::FuncEncode, 24'h000000, 30'h3FFFFFFF);
    send_request(hc2924_pkg::FuncEncode, 24'hFFFFFF, 30'h00000000);
    send_request(hc2924_pkg::FuncEncode, 24'h800000, 30'h15555555);
    send_request(hc2924_pkg::FuncEncode, 24'h000001, 30'h2AAAAAAA);
    send_request(hc2924_pkg::FuncEncode, 24'hA5A5A5, 30'h3FFFFFFF);
  endtask

  // decode: clean words, single errors on parity, data and the spare bit,
  // double error, syndrome 31
  task automatic test_decode_cases();
    hc2924_pkg::code_word_t base;
    base = {1'b0, hamming_encode(24'hFFFFFF)};
    send_request(hc2924_pkg::FuncDecode, 24'hFFFFFF, 30'h00000000);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, 30'h3FFFFFFF);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base ^ 30'h00000001);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base ^ 30'h00008000);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base ^ 30'h00000004);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base ^ 30'h10000000);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base ^ 30'h20000000);
    send_request(hc2924_pkg::FuncDecode, 24'hFFFFFF, base ^ 30'h00000044);
    base = {1'b0, hamming_encode(24'h800000)};
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base ^ 30'h00000004);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, 30'h20000001);
    send_request(hc2924_pkg::FuncDecode, 24'h000000, base ^ 30'h20000001);
    send_request(hc2924_pkg::FuncDecode, 24'hFFFFFF, 30'h15555555);
  endtask

  // encode requests, and decodes of mostly valid code words with zero, one or two flipped bits, some raw noise
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    hc2924_pkg::data_word_t d;
    hc2924_pkg::code_word_t c;
    int                     pick;
    logic [4:0]             p1;
    logic [4:0]             p2;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      d    = 24'($urandom);
      c    = 30'($urandom);
      p1   = 5'($urandom_range(29));
      p2   = 5'($urandom_range(29));
      if (pick < 30) begin
        send_request(hc2924_pkg::FuncEncode, d, c);
      end else begin
        if (pick < 90) begin
          c = {1'b0, hamming_encode(d)};
          if (pick >= 45) c[p1] = ~c[p1];
          if (pick >= 80) c[p2] = ~c[p2];
        end
        d = 24'($urandom);
        send_request(hc2924_pkg::FuncDecode, d, c);
      end
      if (i == n_items / 2) wait_for_drain();
    end
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_extremes();
    test_decode_cases();
    wait_for_drain();
    test_random_traffic(370, 16, 67);
    test_random_traffic(370, 67, 16);
    test_random_traffic(370, 0, 0);
    in_valid <= 1'b0;
    for (int t = 0; t < 20000 && outstanding != 0; t++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (outstanding != 0) begin
      report_mismatch($sformatf("%0d results never arrived", outstanding));
    end
    if (error_count == 0) begin
      $display("PASS hamming_29_24_codec_top");
    end else begin
      $display("FAIL hamming_29_24_codec_top");
    end
    $finish;
  end

endmodule

// ===== hamming_29_24_codec_top.f =====
hdl/hc2924_pkg.sv
hdl/hamming_29_24_codec_top.sv
hdl/hc2924_checker.sv
sim/testbench.sv
